FILE: hdl/rdsaf_pkg.sv
`timescale 1ns / 1ps
package rdsaf_pkg;

  localparam logic [7:0] CODE_HDR_LO  = 8'd224;
  localparam logic [7:0] CODE_HDR_HI  = 8'd249;
  localparam logic [7:0] CODE_LFMF    = 8'd250;
  localparam logic [7:0] CODE_FILLER  = 8'd205;
  localparam logic [7:0] CODE_VHF_MAX = 8'd204;
  localparam logic [7:0] CODE_LF_MAX  = 8'd15;
  localparam logic [7:0] CODE_MF_MIN  = 8'd16;
  localparam logic [7:0] CODE_MF_MAX  = 8'd135;
  localparam logic [3:0] VAR_AF       = 4'h4;
  localparam logic [3:0] VAR_LFMF     = 4'h9;
  localparam logic [1:0] KIND_0A      = 2'd0;
  localparam logic [1:0] KIND_14A     = 2'd1;

  localparam logic [17:0] VHF_BASE = 18'd87600;
  localparam logic [17:0] LF_BASE  = 18'd153;
  localparam logic [17:0] MF_BASE  = 18'd531;

  localparam int ENTRY_W = 37;

  typedef enum logic [1:0] {
    ST_EMPTY      = 2'd0,
    ST_INCOMPLETE = 2'd1,
    ST_COMPLETE   = 2'd2,
    ST_ERROR      = 2'd3
  } list_st_t;

  typedef enum logic [1:0] {
    CLS_IGNORE = 2'd0,
    CLS_CLEAR  = 2'd1,
    CLS_LIST   = 2'd2,
    CLS_EON    = 2'd3
  } cls_t;

  typedef struct packed {
    cls_t       cls;
    logic [3:0] variant;
    logic [7:0] c0;
    logic [7:0] c1;
  } q_item_t;

  typedef struct packed {
    logic signed [17:0] khz;
    logic               pend;
  } conv_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DECODE,
    BK_START,
    BK_WALK,
    BK_NEXT,
    BK_RESULT
  } bk_state_t;

  function automatic logic signed [17:0] vhf_khz(logic [7:0] c);
    logic [17:0] t;
    t = ({10'd0, c} - 18'd1) * 18'd100 + VHF_BASE;
    return $signed(t);
  endfunction

  // Converts one AF code; an LF/MF announcement changes how the next code reads.
  function automatic conv_t af_conv(logic [7:0] c, logic pend);
    conv_t r;
    logic [17:0] t;
    r.khz  = -18'sd1;
    r.pend = pend;
    t      = 18'd0;
    if (c == CODE_FILLER) begin
      r.khz = 18'sd0;
    end else if (c == CODE_LFMF) begin
      r.khz  = 18'sd1;
      r.pend = 1'b1;
    end else if (pend) begin
      r.pend = 1'b0;
      if (c >= 8'd1 && c <= CODE_LF_MAX) begin
        t     = ({10'd0, c} - 18'd1) * 18'd9 + LF_BASE;
        r.khz = $signed(t);
      end else if (c >= CODE_MF_MIN && c <= CODE_MF_MAX) begin
        t     = ({10'd0, c} - {10'd0, CODE_MF_MIN}) * 18'd9 + MF_BASE;
        r.khz = $signed(t);
      end
    end else if (c >= 8'd1 && c <= CODE_VHF_MAX) begin
      r.khz = vhf_khz(c);
    end
    return r;
  endfunction

endpackage

FILE: hdl/rdsaf_ram.sv
`timescale 1ns / 1ps
module rdsaf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/rdsaf_front.sv
`timescale 1ns / 1ps
module rdsaf_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                req_type,
  input  logic                group_complete,
  input  logic [1:0]          group_kind,
  input  logic [3:0]          variant_code,
  input  logic [7:0]          af_code_first,
  input  logic [7:0]          af_code_second,
  output logic                q_valid,
  output rdsaf_pkg::q_item_t  q_item,
  input  logic                q_pop
);

  rdsaf_pkg::q_item_t slot [2];
  rdsaf_pkg::q_item_t item;
  logic               wptr;
  logic               rptr;
  logic [1:0]         fill;
  logic               push;

  always_comb begin
    item.variant = variant_code;
    item.c0      = af_code_first;
    item.c1      = af_code_second;
    if (req_type) begin
      item.cls = rdsaf_pkg::CLS_CLEAR;
    end else if (group_complete && group_kind == rdsaf_pkg::KIND_0A) begin
      item.cls = rdsaf_pkg::CLS_LIST;
    end else if (group_complete && group_kind == rdsaf_pkg::KIND_14A) begin
      item.cls = (variant_code != rdsaf_pkg::VAR_AF) ? rdsaf_pkg::CLS_EON
                                                     : rdsaf_pkg::CLS_LIST;
    end else begin
      item.cls = rdsaf_pkg::CLS_IGNORE;
    end
  end

  assign in_stall = (fill == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (fill != 2'd0);
  assign q_item   = slot[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wptr] <= item;
    end
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (q_pop) begin
        rptr <= ~rptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

FILE: hdl/rdsaf_back.sv
`timescale 1ns / 1ps
module rdsaf_back #(
  parameter int LIST_DEPTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  rdsaf_pkg::q_item_t  q_item,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          list_status,
  output logic [5:0]          entry_count,
  output logic                appended,
  output logic signed [17:0]  new_freq_khz,
  output logic                new_is_variant,
  output logic signed [17:0]  new_mapped_khz,
  output logic                dropped_full
);

  localparam int AW = $clog2(LIST_DEPTH);
  localparam int CW = $clog2(LIST_DEPTH + 1);

  rdsaf_pkg::bk_state_t state, state_next;
  rdsaf_pkg::list_st_t  status;
  rdsaf_pkg::q_item_t   it;

  logic [CW-1:0]      count;
  logic signed [17:0] hdr;
  logic signed [7:0]  rem;
  logic               lfmf;
  logic [CW-1:0]      idx;
  logic               cmp_v;

  logic signed [17:0] cur_freq, cur_map, op2_freq;
  logic               cur_var, has2, eon_flag;
  logic               res_app, res_var, res_drop;
  logic signed [17:0] res_freq, res_map;

  logic                         we;
  logic [rdsaf_pkg::ENTRY_W-1:0] wdata, rdata;

  logic issue, match, walk_end, out_free, add_ok;
  logic signed [7:0] rem_dec;

  rdsaf_pkg::conv_t cv_e, cv_f, cv_1, cv_2;

  rdsaf_ram #(
    .WIDTH (rdsaf_pkg::ENTRY_W),
    .DEPTH (LIST_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (count[AW-1:0]),
    .wdata (wdata),
    .raddr (idx[AW-1:0]),
    .rdata (rdata)
  );

  assign issue    = (idx < count);
  assign match    = cmp_v && (rdata[36:19] == cur_freq) && (rdata[17:0] == cur_map);
  assign walk_end = !cmp_v && !issue;
  assign out_free = !out_valid || !out_stall;
  assign add_ok   = (rem > 8'sd0) || (cur_map > 18'sd0);
  assign rem_dec  = (rem != -8'sd128) ? rem - 8'sd1 : rem;
  assign wdata    = {cur_freq, cur_var, cur_map};
  assign we       = (state == rdsaf_pkg::BK_WALK) && walk_end &&
                    (count < CW'(LIST_DEPTH));

  // EON groups: the variant for LF/MF tunes the second code as LF/MF.
  always_comb begin
    cv_e = rdsaf_pkg::af_conv(it.c0, lfmf);
    cv_f = rdsaf_pkg::af_conv(it.c1, (it.variant == rdsaf_pkg::VAR_LFMF) | cv_e.pend);
    cv_1 = rdsaf_pkg::af_conv(it.c0, lfmf);
    cv_2 = rdsaf_pkg::af_conv(it.c1, cv_1.pend);
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    unique case (state)
      rdsaf_pkg::BK_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = rdsaf_pkg::BK_DECODE;
        end
      end
      rdsaf_pkg::BK_DECODE: begin
        state_next = rdsaf_pkg::BK_RESULT;
        if (it.cls == rdsaf_pkg::CLS_EON) begin
          state_next = rdsaf_pkg::BK_START;
        end else if (it.cls == rdsaf_pkg::CLS_LIST) begin
          if (status == rdsaf_pkg::ST_EMPTY) begin
            if (it.c0 >= rdsaf_pkg::CODE_HDR_LO && it.c0 <= rdsaf_pkg::CODE_HDR_HI &&
                it.c0 != rdsaf_pkg::CODE_HDR_LO && it.c1 != rdsaf_pkg::CODE_LFMF &&
                it.c1 >= 8'd1 && it.c1 <= rdsaf_pkg::CODE_VHF_MAX) begin
              state_next = rdsaf_pkg::BK_START;
            end
          end else if (status == rdsaf_pkg::ST_INCOMPLETE) begin
            if (cv_1.khz >= 18'sd0 && cv_2.khz >= 18'sd0 &&
                (cv_1.khz == hdr || cv_2.khz == hdr ||
                 cv_1.khz > 18'sd1 || cv_2.khz > 18'sd1)) begin
              state_next = rdsaf_pkg::BK_START;
            end
          end
        end
      end
      rdsaf_pkg::BK_START: begin
        state_next = add_ok ? rdsaf_pkg::BK_WALK : rdsaf_pkg::BK_NEXT;
      end
      rdsaf_pkg::BK_WALK: begin
        if (match || walk_end) begin
          state_next = rdsaf_pkg::BK_NEXT;
        end
      end
      rdsaf_pkg::BK_NEXT: begin
        state_next = (has2 && status != rdsaf_pkg::ST_ERROR) ? rdsaf_pkg::BK_START
                                                              : rdsaf_pkg::BK_RESULT;
      end
      rdsaf_pkg::BK_RESULT: begin
        if (out_free) begin
          state_next = rdsaf_pkg::BK_IDLE;
        end
      end
      default: state_next = rdsaf_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rdsaf_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status    <= rdsaf_pkg::ST_EMPTY;
      count     <= '0;
      hdr       <= -18'sd1;
      rem       <= -8'sd1;
      lfmf      <= 1'b0;
      out_valid <= 1'b0;
      cmp_v     <= 1'b0;
      has2      <= 1'b0;
      eon_flag  <= 1'b0;
    end else begin
      if (state == rdsaf_pkg::BK_RESULT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        rdsaf_pkg::BK_IDLE: begin
          if (q_valid) begin
            it       <= q_item;
            res_app  <= 1'b0;
            res_var  <= 1'b0;
            res_drop <= 1'b0;
            res_freq <= 18'sd0;
            res_map  <= 18'sd0;
            has2     <= 1'b0;
            eon_flag <= 1'b0;
            cur_var  <= 1'b0;
            cur_map  <= 18'sd0;
          end
        end
        rdsaf_pkg::BK_DECODE: begin
          unique case (it.cls)
            rdsaf_pkg::CLS_CLEAR: begin
              status <= rdsaf_pkg::ST_EMPTY;
              count  <= '0;
              hdr    <= -18'sd1;
              rem    <= -8'sd1;
              lfmf   <= 1'b0;
            end
            rdsaf_pkg::CLS_IGNORE: begin
            end
            rdsaf_pkg::CLS_EON: begin
              lfmf     <= cv_f.pend;
              cur_freq <= cv_f.khz;
              cur_map  <= cv_e.khz;
              eon_flag <= 1'b1;
            end
            rdsaf_pkg::CLS_LIST: begin
              unique case (status)
                rdsaf_pkg::ST_EMPTY: begin
                  if (it.c0 >= rdsaf_pkg::CODE_HDR_LO && it.c0 <= rdsaf_pkg::CODE_HDR_HI) begin
                    rem <= $signed(it.c0 - rdsaf_pkg::CODE_HDR_LO);
                    if (it.c0 == rdsaf_pkg::CODE_HDR_LO) begin
                      status <= rdsaf_pkg::ST_COMPLETE;
                    end else if (it.c1 == rdsaf_pkg::CODE_LFMF) begin
                      lfmf   <= 1'b1;
                      status <= rdsaf_pkg::ST_INCOMPLETE;
                    end else if (it.c1 >= 8'd1 && it.c1 <= rdsaf_pkg::CODE_VHF_MAX) begin
                      hdr      <= rdsaf_pkg::vhf_khz(it.c1);
                      cur_freq <= rdsaf_pkg::vhf_khz(it.c1);
                    end else begin
                      status <= rdsaf_pkg::ST_ERROR;
                    end
                  end else begin
                    status <= rdsaf_pkg::ST_ERROR;
                  end
                end
                rdsaf_pkg::ST_INCOMPLETE: begin
                  if (cv_1.khz < 18'sd0) begin
                    lfmf <= cv_1.pend;
                  end else begin
                    lfmf <= cv_2.pend;
                    if (cv_2.khz >= 18'sd0) begin
                      if (cv_1.khz == hdr || cv_2.khz == hdr) begin
                        // Method B pair: the other frequency, flagged when the second is lower than the first.
                        cur_freq <= (cv_1.khz == hdr) ? cv_2.khz : cv_1.khz;
                        cur_var  <= (cv_2.khz < cv_1.khz);
                      end else if (cv_1.khz > 18'sd1) begin
                        cur_freq <= cv_1.khz;
                        op2_freq <= cv_2.khz;
                        has2     <= (cv_2.khz > 18'sd1);
                      end else begin
                        cur_freq <= cv_2.khz;
                      end
                    end
                  end
                end
                rdsaf_pkg::ST_ERROR: begin
                  status <= rdsaf_pkg::ST_EMPTY;
                  count  <= '0;
                  hdr    <= -18'sd1;
                  rem    <= -8'sd1;
                  lfmf   <= 1'b0;
                end
                rdsaf_pkg::ST_COMPLETE: begin
                  status <= rdsaf_pkg::ST_ERROR;
                end
              endcase
            end
          endcase
        end
        rdsaf_pkg::BK_START: begin
          idx   <= '0;
          cmp_v <= 1'b0;
          if (!add_ok) begin
            status <= rdsaf_pkg::ST_ERROR;
          end
        end
        rdsaf_pkg::BK_WALK: begin
          // One read issued per cycle; its data is compared on the next cycle.
          cmp_v <= issue && !match;
          if (issue) begin
            idx <= idx + CW'(1);
          end
          if (walk_end) begin
            if (count >= CW'(LIST_DEPTH)) begin
              res_drop <= 1'b1;
            end else begin
              count    <= count + CW'(1);
              rem      <= rem_dec;
              status   <= (rem_dec == 8'sd0) ? rdsaf_pkg::ST_COMPLETE
                                             : rdsaf_pkg::ST_INCOMPLETE;
              res_app  <= 1'b1;
              res_freq <= cur_freq;
              res_var  <= cur_var;
              res_map  <= cur_map;
            end
          end
        end
        rdsaf_pkg::BK_NEXT: begin
          if (has2 && status != rdsaf_pkg::ST_ERROR) begin
            cur_freq <= op2_freq;
            cur_var  <= 1'b0;
            cur_map  <= 18'sd0;
            has2     <= 1'b0;
          end else if (eon_flag) begin
            status <= rdsaf_pkg::ST_COMPLETE;
          end
        end
        rdsaf_pkg::BK_RESULT: begin
          if (out_free) begin
            list_status    <= status;
            entry_count    <= 6'(count);
            appended       <= res_app;
            new_freq_khz   <= res_freq;
            new_is_variant <= res_var;
            new_mapped_khz <= res_map;
            dropped_full   <= res_drop;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: hdl/rds_af_list_decoder_unit.sv
`timescale 1ns / 1ps
// RDS alternative-frequency list decoder.
// Input channel (in_valid/in_stall): one decoded group or a clear request per
// transfer. A front stage classifies each item and holds up to two items in a
// queue; in_stall rises only while that queue is full.
// Output channel (out_valid/out_stall): exactly one result per input item, in
// order, held in an output register until it is taken. While the receiver
// stalls, the back stage finishes its current item and then waits.
// An item with no list entry to add passes the back-stage states IDLE, DECODE
// and RESULT before its result is registered. Each add walks the stored entries
// in the entry RAM, one read per cycle, and a Method A pair makes up to two
// adds; the back stage takes no new item until its current one is done.
// That walk over the single-read-port RAM sets the throughput.
// Reset (rst, synchronous) empties the list, the queue and the output
// register; stored entries are not cleared since only counted ones are read.
module rds_af_list_decoder_unit #(
  parameter int LIST_DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               req_type,
  input  logic               group_complete,
  input  logic [1:0]         group_kind,
  input  logic [3:0]         variant_code,
  input  logic [7:0]         af_code_first,
  input  logic [7:0]         af_code_second,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         list_status,
  output logic [5:0]         entry_count,
  output logic               appended,
  output logic signed [17:0] new_freq_khz,
  output logic               new_is_variant,
  output logic signed [17:0] new_mapped_khz,
  output logic               dropped_full
);

  logic               q_valid;
  logic               q_pop;
  rdsaf_pkg::q_item_t q_item;

  rdsaf_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .req_type       (req_type),
    .group_complete (group_complete),
    .group_kind     (group_kind),
    .variant_code   (variant_code),
    .af_code_first  (af_code_first),
    .af_code_second (af_code_second),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop)
  );

  rdsaf_back #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .list_status    (list_status),
    .entry_count    (entry_count),
    .appended       (appended),
    .new_freq_khz   (new_freq_khz),
    .new_is_variant (new_is_variant),
    .new_mapped_khz (new_mapped_khz),
    .dropped_full   (dropped_full)
  );

endmodule
